FILE: src/heightmap_vertex_normal_stream_assert.svh
// assertion macros for the rtl, included by hvn_back
`ifndef HEIGHTMAP_VERTEX_NORMAL_STREAM_ASSERT_SVH
`define HEIGHTMAP_VERTEX_NORMAL_STREAM_ASSERT_SVH

// same-cycle implication, checked outside reset
`define HVN_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define HVN_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/hvn_pkg.sv
`timescale 1ns / 1ps
package hvn_pkg;

   // register indexes
   localparam logic [2:0] REG_GRID_SIDE     = 3'd0;
   localparam logic [2:0] REG_HEIGHT_OFFSET = 3'd1;
   localparam logic [2:0] REG_HEIGHT_GAIN   = 3'd2;
   localparam logic [2:0] REG_HEIGHT_LIMIT  = 3'd3;
   localparam logic [2:0] REG_GRID_STEP     = 3'd4;

   localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
   localparam int QUEUE_DEPTH = 4;

   // one vertex handed from front to back
   typedef struct packed {
      logic [9:0]         col;
      logic [9:0]         row;
      logic signed [23:0] height;
      logic               interior;
      logic signed [24:0] vx;
      logic signed [24:0] vz;
      logic               last;
   } hvn_job_type;

endpackage

FILE: src/hvn_queue.sv
`timescale 1ns / 1ps
module hvn_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  hvn_pkg::hvn_job_type push_job,
   output logic                push_ready,
   output logic                pop_valid,
   output hvn_pkg::hvn_job_type pop_job,
   input  logic                pop_ready
);
   import hvn_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);

   hvn_job_type       slot_ff [QUEUE_DEPTH];
   logic [AW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [AW:0]       count_ff;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != (AW+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_job;
   end

endmodule

FILE: src/hvn_front.sv
`timescale 1ns / 1ps
module hvn_front #(
   parameter int MAX_SIDE = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                csr_wr_en,
   input  logic [2:0]          csr_index,
   input  logic [23:0]         csr_wr_data,
   output logic                push_valid,
   output hvn_pkg::hvn_job_type push_job,
   input  logic                push_ready,
   output logic [24:0]         step_dbl
);
   import hvn_pkg::*;

   localparam int CW = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
   localparam int SW = ($clog2(MAX_SIDE + 1) > 11) ? $clog2(MAX_SIDE + 1) : 11;

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_MUL  = 2'd1;
   localparam logic [1:0] F_CALC = 2'd2;
   localparam logic [1:0] F_PUSH = 2'd3;

   logic [10:0]        side_ff;
   logic signed [16:0] offset_ff;
   logic [23:0]        gain_ff;
   logic signed [23:0] limit_ff;
   logic [23:0]        step_ff;

   logic [1:0]         state_ff, state_in;
   logic [CW-1:0]      col_ff, row_ff;
   logic [7:0]         sample_ff;
   logic [23:0]        rd_one_ff, rd_two_ff;
   logic signed [42:0] prod_ff;
   logic signed [23:0] win_ff [4];
   logic [1:0]         phase_ff;
   logic [2:0]         emit_ff;
   hvn_job_type        job_ff [3];

   logic [23:0]        line_one_mem [MAX_SIDE];
   logic [23:0]        line_two_mem [MAX_SIDE];

   logic [SW-1:0]      side_ext, side_eff, last_idx, c_ext, r_ext;
   logic signed [17:0] t_val;
   logic signed [24:0] gain_s;
   logic signed [42:0] prod_in;
   logic signed [26:0] q_val;
   logic signed [23:0] h_sat, h_val, right_h;
   logic               e1, e2, e3, inner, at_row_end;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff   <= 11'd1024;
         offset_ff <= '0;
         gain_ff   <= 24'd65536;
         limit_ff  <= 24'sd65280;
         step_ff   <= 24'd256;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_GRID_SIDE:     side_ff   <= csr_wr_data[10:0];
            REG_HEIGHT_OFFSET: offset_ff <= signed'(csr_wr_data[16:0]);
            REG_HEIGHT_GAIN:   gain_ff   <= csr_wr_data;
            REG_HEIGHT_LIMIT:  limit_ff  <= signed'(csr_wr_data);
            REG_GRID_STEP:     step_ff   <= csr_wr_data;
            default:           ;
         endcase
      end
   end

   assign step_dbl = {(step_ff == '0) ? 24'd1 : step_ff, 1'b0};

   // effective side, clamped to the supported range
   always_comb begin
      side_ext = SW'(side_ff);
      if (side_ext < SW'(3))             side_eff = SW'(3);
      else if (side_ext > SW'(MAX_SIDE)) side_eff = SW'(MAX_SIDE);
      else                               side_eff = side_ext;
      last_idx = side_eff - 1'b1;
      c_ext    = SW'(col_ff);
      r_ext    = SW'(row_ff);
   end

   // height scaling
   always_comb begin
      t_val   = signed'({2'b00, sample_ff, 8'h00}) + 18'(offset_ff);
      gain_s  = signed'({1'b0, gain_ff});
      prod_in = 43'(t_val) * 43'(gain_s);
      q_val   = prod_ff[42:16];
      if (q_val > 27'sd8388607)       h_sat = 24'sh7fffff;
      else if (q_val < -27'sd8388608) h_sat = 24'sh800000;
      else                            h_sat = q_val[23:0];
      h_val   = (h_sat > limit_ff) ? limit_ff : h_sat;
      right_h = signed'(rd_one_ff);
   end

   // which vertices this sample completes
   always_comb begin
      at_row_end = (c_ext >= last_idx);
      e1    = (r_ext >= SW'(1)) && (c_ext >= SW'(1));
      e2    = (r_ext >= SW'(1)) && at_row_end;
      e3    = (r_ext >= last_idx);
      inner = (c_ext >= SW'(2)) && (c_ext <= last_idx) &&
              (r_ext >= SW'(2)) && (r_ext <= last_idx);
   end

   assign req_tready = (state_ff == F_IDLE) && !reset;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE:  if (req_tvalid) state_in = F_MUL;
         F_MUL:   state_in = F_CALC;
         F_CALC:  state_in = F_PUSH;
         F_PUSH:  if ((!emit_ff[phase_ff] || push_ready) && phase_ff == 2'd2)
                     state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   // control state: counters, window, emit phase
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         phase_ff <= '0;
         emit_ff  <= '0;
         for (int i = 0; i < 4; i++) win_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            F_CALC: begin
               emit_ff   <= {e3, e2, e1};
               phase_ff  <= '0;
               win_ff[0] <= win_ff[1];
               win_ff[1] <= right_h;
               win_ff[2] <= signed'(rd_two_ff);
               win_ff[3] <= h_val;
               if (at_row_end) begin
                  col_ff <= '0;
                  row_ff <= e3 ? '0 : row_ff + 1'b1;
               end else begin
                  col_ff <= col_ff + 1'b1;
               end
            end
            F_PUSH: if (!emit_ff[phase_ff] || push_ready) phase_ff <= phase_ff + 1'b1;
            default: ;
         endcase
      end
   end

   // sample capture, product and candidate vertices
   always_ff @(posedge clock) begin
      if (state_ff == F_IDLE && req_tvalid) sample_ff <= req_tdata;
      if (state_ff == F_MUL) prod_ff <= prod_in;
      if (state_ff == F_CALC) begin
         job_ff[0].col      <= 10'(col_ff - 1'b1);
         job_ff[0].row      <= 10'(row_ff - 1'b1);
         job_ff[0].height   <= win_ff[1];
         job_ff[0].interior <= inner;
         job_ff[0].vx       <= 25'(win_ff[0]) - 25'(right_h);
         job_ff[0].vz       <= 25'(win_ff[2]) - 25'(win_ff[3]);
         job_ff[0].last     <= !e2 && !e3;
         job_ff[1].col      <= 10'(col_ff);
         job_ff[1].row      <= 10'(row_ff - 1'b1);
         job_ff[1].height   <= right_h;
         job_ff[1].interior <= 1'b0;
         job_ff[1].vx       <= '0;
         job_ff[1].vz       <= '0;
         job_ff[1].last     <= !e3;
         job_ff[2].col      <= 10'(col_ff);
         job_ff[2].row      <= 10'(row_ff);
         job_ff[2].height   <= h_val;
         job_ff[2].interior <= 1'b0;
         job_ff[2].vx       <= '0;
         job_ff[2].vz       <= '0;
         job_ff[2].last     <= 1'b1;
      end
   end

   // line stores, registered read at request accept
   always_ff @(posedge clock) begin
      if (state_ff == F_IDLE && req_tvalid) begin
         rd_one_ff <= line_one_mem[col_ff];
         rd_two_ff <= line_two_mem[col_ff];
      end
      if (state_ff == F_CALC) begin
         line_one_mem[col_ff] <= h_val;
         line_two_mem[col_ff] <= rd_one_ff;
      end
   end

   assign push_valid = (state_ff == F_PUSH) && (phase_ff != 2'd3) && emit_ff[phase_ff];
   assign push_job   = job_ff[(phase_ff == 2'd3) ? 2'd2 : phase_ff];

endmodule

FILE: src/hvn_back.sv
`timescale 1ns / 1ps
`include "heightmap_vertex_normal_stream_assert.svh"
module hvn_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   input  hvn_pkg::hvn_job_type pop_job,
   output logic                pop_ready,
   input  logic [24:0]         step_dbl,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [95:0]         rsp_tdata,
   output logic                rsp_tlast
);
   import hvn_pkg::*;

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_SQ   = 2'd1;
   localparam logic [1:0] B_SQRT = 2'd2;
   localparam logic [1:0] B_DIV  = 2'd3;

   logic [1:0]         state_ff;
   logic [4:0]         cnt_ff;
   logic [1:0]         comp_ff;
   logic [24:0]        mag_ff [3];
   logic               neg_x_ff, neg_z_ff;
   logic [49:0]        prod_ff;
   logic [51:0]        acc_ff;
   logic [61:0]        x_ff, res_ff, bit_ff;
   logic [45:0]        rem_ff, dv_ff;
   logic [14:0]        q_ff;
   logic signed [15:0] nrm_ff [2];
   logic [9:0]         col_ff, row_ff;
   logic signed [23:0] height_ff;
   logic               last_ff;
   logic               rsp_valid_ff;
   logic [9:0]         o_col_ff, o_row_ff;
   logic signed [23:0] o_height_ff;
   logic signed [15:0] o_nx_ff, o_ny_ff, o_nz_ff;
   logic               o_last_ff;

   logic [24:0]        sq_sel, abs_vx, abs_vz;
   logic [51:0]        acc_sum;
   logic [61:0]        trial;
   logic               take_root, ge;
   logic [14:0]        q_nx;
   logic signed [15:0] n_val;
   logic [30:0]        root;
   logic               neg_now;

   assign pop_ready = (state_ff == B_IDLE) && !rsp_valid_ff;

   // datapath helpers
   always_comb begin
      abs_vx    = pop_job.vx[24] ? 25'(-pop_job.vx) : 25'(pop_job.vx);
      abs_vz    = pop_job.vz[24] ? 25'(-pop_job.vz) : 25'(pop_job.vz);
      sq_sel    = mag_ff[(cnt_ff[1:0] == 2'd3) ? 2'd2 : cnt_ff[1:0]];
      acc_sum   = acc_ff + 52'(prod_ff);
      trial     = res_ff + bit_ff;
      take_root = (x_ff >= trial);
      root      = res_ff[30:0];
      ge        = (rem_ff >= dv_ff);
      q_nx      = {q_ff[13:0], ge};
      neg_now   = (comp_ff == 2'd0) ? neg_x_ff : (comp_ff == 2'd2) ? neg_z_ff : 1'b0;
      n_val     = neg_now ? -signed'({1'b0, q_nx}) : signed'({1'b0, q_nx});
   end

   // sequencer: border hand-off, or squares, root and three divisions
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         comp_ff      <= '0;
      end else begin
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            B_IDLE: begin
               if (pop_valid && !rsp_valid_ff) begin
                  if (pop_job.interior) begin
                     state_ff <= B_SQ;
                     cnt_ff   <= '0;
                  end else begin
                     rsp_valid_ff <= 1'b1;
                  end
               end
            end
            B_SQ: begin
               if (cnt_ff == 5'd3) begin
                  state_ff <= B_SQRT;
                  cnt_ff   <= '0;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            B_SQRT: begin
               if (cnt_ff == 5'd30) begin
                  state_ff <= B_DIV;
                  cnt_ff   <= '0;
                  comp_ff  <= '0;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            B_DIV: begin
               if (cnt_ff == 5'd15) begin
                  cnt_ff <= '0;
                  if (comp_ff == 2'd2) begin
                     state_ff     <= B_IDLE;
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     comp_ff <= comp_ff + 1'b1;
                  end
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            col_ff    <= pop_job.col;
            row_ff    <= pop_job.row;
            height_ff <= pop_job.height;
            last_ff   <= pop_job.last;
            mag_ff[0] <= abs_vx;
            mag_ff[1] <= step_dbl;
            mag_ff[2] <= abs_vz;
            neg_x_ff  <= pop_job.vx[24];
            neg_z_ff  <= pop_job.vz[24];
            prod_ff   <= '0;
            acc_ff    <= '0;
            if (pop_valid && !rsp_valid_ff && !pop_job.interior) begin
               o_col_ff    <= pop_job.col;
               o_row_ff    <= pop_job.row;
               o_height_ff <= pop_job.height;
               o_nx_ff     <= '0;
               o_ny_ff     <= ONE_Q14;
               o_nz_ff     <= '0;
               o_last_ff   <= pop_job.last;
            end
         end
         B_SQ: begin
            prod_ff <= 50'(sq_sel) * 50'(sq_sel);
            acc_ff  <= acc_sum;
            x_ff    <= {acc_sum, 10'b0};
            res_ff  <= '0;
            bit_ff  <= 62'h1 << 60;
         end
         B_SQRT: begin
            if (take_root) begin
               x_ff   <= x_ff - trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         B_DIV: begin
            if (cnt_ff == 5'd0) begin
               rem_ff <= ({21'b0, mag_ff[comp_ff]} << 19) + 46'(root >> 1);
               dv_ff  <= 46'(root) << 14;
               q_ff   <= '0;
            end else begin
               if (ge) rem_ff <= rem_ff - dv_ff;
               dv_ff <= dv_ff >> 1;
               q_ff  <= q_nx;
               if (cnt_ff == 5'd15) begin
                  if (comp_ff != 2'd2) nrm_ff[comp_ff[0]] <= n_val;
                  else begin
                     o_col_ff    <= col_ff;
                     o_row_ff    <= row_ff;
                     o_height_ff <= height_ff;
                     o_nx_ff     <= nrm_ff[0];
                     o_ny_ff     <= nrm_ff[1];
                     o_nz_ff     <= n_val;
                     o_last_ff   <= last_ff;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = o_last_ff;
   assign rsp_tdata  = {4'b0, o_nz_ff, o_ny_ff, o_nx_ff, o_height_ff, o_row_ff, o_col_ff};

   `HVN_ASSERT_NOW(a_root_nonzero, state_ff == B_DIV, root != '0, "zero root in divide")
   `HVN_ASSERT_NOW(a_nx_range, rsp_valid_ff,
      o_nx_ff <= ONE_Q14 && o_nx_ff >= -ONE_Q14, "normal x out of range")
   `HVN_ASSERT_NEXT(a_border_out,
      state_ff == B_IDLE && pop_valid && !rsp_valid_ff && !pop_job.interior,
      rsp_valid_ff && o_ny_ff == ONE_Q14, "border vertex not emitted")

endmodule

FILE: src/heightmap_vertex_normal_stream.sv
`timescale 1ns / 1ps
// heightmap vertex and normal stream
// req channel: one 8-bit height sample per request, raster order, column fastest.
// rsp channel: vertices (col, row, height Q16.8, normal Q1.14 x/y/z); tlast marks
//   the final vertex produced by one request. A request in row 0 produces none.
// csr port: write enable, index, data; write only while the block is idle.
// front: each request passes accept (line-store read), multiply, calc and push;
//   push offers the three candidates in turn, and a new request waits for it.
// back: a border vertex goes straight to the output register; an interior vertex
//   passes the sum of squares, the serial square root (one bit a cycle) and
//   three 15-step restoring divisions on one shared divider.
// a 4-entry queue between front and back lets each side stall on its own.
// reset: counters, window and config return to defaults; the line stores are
//   not cleared and hold nothing valid until written by the first rows.
// when the receiver stalls the output register holds, the queue fills and
//   then the request side stops accepting.
module heightmap_vertex_normal_stream #(
   parameter int MAX_SIDE = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] height_sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // vertex_col, vertex_row, vertex_height,
                                    // normal_x, normal_y, normal_z, zero fill
   output logic        rsp_tlast,   // last_of_run
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wr_data
);
   import hvn_pkg::*;

   hvn_job_type push_job, pop_job;
   logic        push_valid, push_ready, pop_valid, pop_ready;
   logic [24:0] step_dbl;

   // front: accept, scale, line stores
   hvn_front #(.MAX_SIDE(MAX_SIDE)) u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .csr_wr_en, .csr_index, .csr_wr_data,
      .push_valid, .push_job, .push_ready, .step_dbl
   );

   // vertex queue
   hvn_queue u_queue (
      .clock, .reset, .push_valid, .push_job, .push_ready,
      .pop_valid, .pop_job, .pop_ready
   );

   // back: normals and output register
   hvn_back u_back (
      .clock, .reset, .pop_valid, .pop_job, .pop_ready, .step_dbl,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast
   );

endmodule

FILE: test/heightmap_vertex_normal_stream_tb.sv
`timescale 1ns / 1ps
module heightmap_vertex_normal_stream_tb;
   import hvn_pkg::*;

   localparam int SIDE_CAP = 1024;
   localparam int DRAIN_CYCLES = 120;
   localparam int IDLE_LIMIT = 20000;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      logic [9:0]         col;
      logic [9:0]         row;
      logic signed [23:0] height;
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
      logic               last;
   } vertex_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;    // [7:0] height_sample
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;           // col, row, height, nx, ny, nz, zero fill
   logic        rsp_tlast;           // last_of_run
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = REG_GRID_SIDE;
   logic [23:0] csr_wr_data = 24'd0;

   heightmap_vertex_normal_stream i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   always #4 clock = ~clock;

   // predictor state
   int unsigned cfg_side = 1024;
   longint      cfg_offset = 0;
   longint      cfg_gain = 65536;
   longint      cfg_limit = 65280;
   longint      cfg_step = 256;
   int          up_one[SIDE_CAP];
   int          up_two[SIDE_CAP];
   int          win[4];
   int unsigned col_cnt = 0;
   int unsigned row_cnt = 0;

   vertex_type  pending_vertices[$];
   int          mismatch_count = 0;
   bit          idle_on = 1'b1;
   int          hold_count = 0;

   // receiver-side and watchdog bookkeeping
   int          hold_done = 0;
   int          hold_left = 0;
   int          rsp_gap = 0;
   int          idle_cycles = 0;

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic signed [15:0] unit_comp(longint v, longint unsigned len);
      longint unsigned a;
      longint unsigned m;
      a = (v < 0) ? longint'(-v) : longint'(v);
      m = ((a << 19) + (len >> 1)) / len;
      return (v < 0) ? 16'(-longint'(m)) : 16'(m);
   endfunction

   function automatic int scaled_height(logic [7:0] sample);
      longint t;
      longint q;
      t = longint'(sample) * 256 + cfg_offset;
      q = (t * cfg_gain) >>> 16;
      if (q > 8388607) q = 8388607;
      if (q < -8388608) q = -8388608;
      if (q > cfg_limit) q = cfg_limit;
      return int'(q);
   endfunction

   function automatic void push_vertex(int unsigned c, int unsigned r, int h,
                                       logic signed [15:0] nx, logic signed [15:0] ny,
                                       logic signed [15:0] nz);
      vertex_type v;
      v.col = 10'(c);
      v.row = 10'(r);
      v.height = 24'(h);
      v.nx = nx;
      v.ny = ny;
      v.nz = nz;
      v.last = 1'b0;
      pending_vertices.push_back(v);
   endfunction

   // expected vertices for one accepted sample
   function automatic void predict_vertices(logic [7:0] sample);
      int unsigned s;
      int unsigned c;
      int unsigned r;
      int unsigned idx;
      int unsigned vc;
      int unsigned vr;
      int          h;
      int          right;
      int          below2;
      int          n;
      longint      vx;
      longint      vy;
      longint      vz;
      longint unsigned len;
      s = cfg_side;
      c = col_cnt;
      r = row_cnt;
      idx = (c < SIDE_CAP) ? c : SIDE_CAP - 1;
      n = 0;
      if (s < 3) s = 3;
      if (s > SIDE_CAP) s = SIDE_CAP;
      h = scaled_height(sample);
      right = up_one[idx];
      below2 = up_two[idx];
      if (r >= 1 && c >= 1) begin
         vc = c - 1;
         vr = r - 1;
         if (vc >= 1 && vc <= s - 2 && vr >= 1 && vr <= s - 2) begin
            vx = longint'(win[0]) - longint'(right);
            vy = 2 * cfg_step;
            vz = longint'(win[2]) - longint'(win[3]);
            len = int_sqrt(longint'(vx * vx + vy * vy + vz * vz) << 10);
            push_vertex(vc, vr, win[1], unit_comp(vx, len), unit_comp(vy, len),
                        unit_comp(vz, len));
         end else begin
            push_vertex(vc, vr, win[1], 16'sd0, ONE_Q14, 16'sd0);
         end
         n++;
      end
      if (r >= 1 && c >= s - 1) begin
         push_vertex(c, r - 1, right, 16'sd0, ONE_Q14, 16'sd0);
         n++;
      end
      if (r >= s - 1) begin
         push_vertex(c, r, h, 16'sd0, ONE_Q14, 16'sd0);
         n++;
      end
      if (n > 0) pending_vertices[pending_vertices.size() - 1].last = 1'b1;
      win[0] = win[1];
      win[1] = right;
      win[2] = below2;
      win[3] = h;
      up_two[idx] = right;
      up_one[idx] = h;
      if (c >= s - 1) begin
         col_cnt = 0;
         row_cnt = (r >= s - 1) ? 0 : r + 1;
      end else begin
         col_cnt = c + 1;
      end
   endfunction

   // one request, with an optional idle burst before it
   task automatic send_sample(logic [7:0] sample);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= sample;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      predict_vertices(sample);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_vertices.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write enable stays high across back-to-back writes; setup drops it
   task automatic write_reg(logic [2:0] index, logic [23:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wr_data <= value;
      @(posedge clock);
      case (index)
         REG_GRID_SIDE:     cfg_side = int'(value[10:0]);
         REG_HEIGHT_OFFSET: cfg_offset = longint'($signed(value[16:0]));
         REG_HEIGHT_GAIN:   cfg_gain = longint'(value);
         REG_HEIGHT_LIMIT:  cfg_limit = longint'($signed(value));
         REG_GRID_STEP:     cfg_step = (value == 0) ? 1 : longint'(value);
         default: ;
      endcase
   endtask

   task automatic setup(int side, int ofs, int gain, int lim, int step);
      wait_drained();
      write_reg(REG_GRID_SIDE, 24'(side));
      write_reg(REG_HEIGHT_OFFSET, 24'(ofs));
      write_reg(REG_HEIGHT_GAIN, 24'(gain));
      write_reg(REG_HEIGHT_LIMIT, 24'(lim));
      write_reg(REG_GRID_STEP, 24'(step));
      csr_wr_en <= 1'b0;
   endtask

   // one whole frame; mode 0 random, 1 extremes, 2 smooth slope
   task automatic send_frame(int side, int mode);
      int eff;
      int k;
      logic [7:0] smp;
      eff = (side < 3) ? 3 : side;
      for (k = 0; k < eff * eff; k++) begin
         case (mode)
            1: smp = ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
            2: smp = 8'((k % eff) * 9 + (k / eff) * 5 + $urandom_range(0, 3));
            default: smp = 8'($urandom);
         endcase
         send_sample(smp);
      end
   endtask

   // smallest frames with interior vertices, extreme samples
   task automatic test_small_frames();
      setup(3, 0, 65536, 65280, 256);
      send_sample(8'h00); send_sample(8'hff); send_sample(8'h00);
      send_sample(8'hff); send_sample(8'h80); send_sample(8'h00);
      send_sample(8'h00); send_sample(8'hff); send_sample(8'hff);
      setup(4, 0, 65536, 65280, 256);
      send_frame(4, 1);
   endtask

   // extreme scaling, saturation and clamp, side and step out of range
   task automatic test_scaling_extremes();
      setup(0, -65536, 16777215, 8388607, 0);
      send_frame(3, 1);
      setup(2, 65535, 16777215, -8388608, 16777215);
      send_frame(3, 1);
      setup(5, -300, 1, 1000, 1);
      send_frame(5, 0);
   endtask

   // receiver holds off while requests keep coming
   task automatic test_backpressure();
      setup(6, 512, 70000, 65280, 300);
      hold_count++;
      send_frame(6, 0);
   endtask

   task automatic test_random_frames();
      int sent;
      int side;
      sent = 0;
      while (sent < 80) begin
         side = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(3, 7);
         setup(side, int'($urandom_range(0, 131071)) - 65536, $urandom,
               ($urandom_range(0, 3) == 0) ? int'($urandom) : 8388607,
               $urandom_range(1, 3) == 1 ? $urandom : $urandom_range(1, 2000));
         send_frame(side, $urandom_range(0, 2));
         sent += side * side;
      end
   endtask

   task automatic test_full_rate();
      idle_on = 1'b0;
      setup(8, 0, 65536, 65280, 256);
      send_frame(8, 2);
      wait_drained();
   endtask

   // result checker and receiver pacing
   initial begin
      logic        fire;
      logic [95:0] got;
      logic        got_last;
      vertex_type  exp_v;
      forever begin
         @(negedge clock);
         fire = rsp_tvalid && rsp_tready;
         got = rsp_tdata;
         got_last = rsp_tlast;
         @(posedge clock);
         if (fire) begin
            if (pending_vertices.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected vertex: tdata=%h last=%b", got, got_last);
            end else begin
               exp_v = pending_vertices.pop_front();
               if (got[9:0] !== exp_v.col || got[19:10] !== exp_v.row ||
                   got[43:20] !== exp_v.height || got[59:44] !== exp_v.nx ||
                   got[75:60] !== exp_v.ny || got[91:76] !== exp_v.nz ||
                   got[95:92] !== 4'd0 || got_last !== exp_v.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("vertex mismatch exp col=%0d row=%0d h=%0d n=(%0d,%0d,%0d) last=%b got col=%0d row=%0d h=%0d n=(%0d,%0d,%0d) last=%b fill=%h",
                              exp_v.col, exp_v.row, exp_v.height, exp_v.nx, exp_v.ny,
                              exp_v.nz, exp_v.last, got[9:0], got[19:10],
                              $signed(got[43:20]), $signed(got[59:44]),
                              $signed(got[75:60]), $signed(got[91:76]), got_last,
                              got[95:92]);
               end
            end
         end
         if (hold_done != hold_count) begin
            hold_done = hold_count;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) hold_left--;
         else if (rsp_gap > 0) rsp_gap--;
         else if (idle_on && $urandom_range(0, 7) == 0) rsp_gap = $urandom_range(1, 9);
         rsp_tready <= (hold_left == 0) && (rsp_gap == 0);
      end
   end

   // watchdog on cycles without any handshake
   initial begin
      forever begin
         @(negedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_small_frames();
      test_scaling_extremes();
      test_backpressure();
      test_random_frames();
      test_full_rate();
      if (mismatch_count == 0 && pending_vertices.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
